/* hw/rtl/path_glob_substring_filter_core_assert.svh */
// Assertion macros shared by the path glob / substring filter RTL.
// No dependencies; the clocked forms expect signals named clk and rst in scope.
`ifndef PATH_GLOB_SUBSTRING_FILTER_CORE_ASSERT_SVH
`define PATH_GLOB_SUBSTRING_FILTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PGSF_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define PGSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PGSF_ASSERT(lbl, expr, msg)
`define PGSF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/pgsf_pkg.sv */
// Shared constants, types and helpers for the path glob / substring filter.
// Used by every module of the block; no dependencies of its own.
package pgsf_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int COUNT_BITS  = 16;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int CLOS_STEPS  = $clog2(MAX_PATTERN + 1);
  localparam int PAT_REGS    = 4;
  localparam int PAT_BITS    = PAT_REGS * 64;
  localparam int CFG_LEN_W   = 6;
  localparam int OUT_CNT_W   = 16;
  localparam int S_TDATA_W   = 8;
  localparam int M_TDATA_W   = 40;

  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] STAR_CHAR      = 8'h2A;
  localparam logic [7:0] QMARK_CHAR     = 8'h3F;
  localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;

  localparam logic [2:0] CFG_PAT0   = 3'd0;
  localparam logic [2:0] CFG_PAT1   = 3'd1;
  localparam logic [2:0] CFG_PAT2   = 3'd2;
  localparam logic [2:0] CFG_PAT3   = 3'd3;
  localparam logic [2:0] CFG_LENGTH = 3'd4;
  localparam logic [2:0] CFG_SCOPE  = 3'd5;

  typedef struct packed {
    logic [PAT_BITS-1:0]  pattern;
    logic [CFG_LEN_W-1:0] length;
    logic                 scope_name;
  } cfg_t;

  // one classified path byte on its way from front to back
  typedef struct packed {
    logic [7:0] ch_fold;
    logic       restart;
    logic       last;
    logic       fin;
  } q_entry_t;

  function automatic logic [7:0] fold_char(input logic [7:0] c);
    fold_char = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // Star closure: position i+1 becomes live when i is live and holds '*'.
  // Parallel prefix form, log2 steps.
  function automatic logic [MAX_PATTERN:0] star_close(input logic [MAX_PATTERN:0] s,
                                                      input logic [MAX_PATTERN-1:0] star);
    logic [MAX_PATTERN:0] g;
    logic [MAX_PATTERN:0] p;
    g = s;
    p = {star, 1'b0};
    for (int j = 0; j < CLOS_STEPS; j++) begin
      g = g | (p & (g << (1 << j)));
      p = p & (p << (1 << j));
    end
    star_close = g;
  endfunction

endpackage

/* hw/rtl/pgsf_front.sv */
// Front end: folds each path byte and flags name-scope restarts.
// Depends on pgsf_pkg.
module pgsf_front
  import pgsf_pkg::*;
(
  input  logic [7:0] character,
  input  logic       last_char,
  input  logic       final_path,
  input  logic       scope_name,
  output q_entry_t   entry
);

  always_comb begin
    entry.ch_fold = fold_char(character);
    entry.restart = scope_name && (character == BACKSLASH_CHAR);
    entry.last    = last_char;
    entry.fin     = final_path;
  end

endmodule

/* hw/rtl/pgsf_queue.sv */
// Short FIFO between front end and match engine.
// Depends on pgsf_pkg and the assertion macro header.
`include "path_glob_substring_filter_core_assert.svh"

module pgsf_queue
  import pgsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  q_entry_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output q_entry_t out_data
);

  q_entry_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]     wr_ptr;
  logic [Q_PTR_W-1:0]     rd_ptr;
  logic [Q_CNT_W-1:0]     count;
  logic                   push;
  logic                   pop;

  assign in_ready  = (count != Q_CNT_W'(Q_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `PGSF_ASSERT(a_cnt_bound, count <= Q_CNT_W'(Q_DEPTH), "queue count over depth")
  `PGSF_ASSERT_NEXT(a_push_only, push && !pop, count == $past(count) + 1'b1, "push lost")
  `PGSF_ASSERT_NEXT(a_pop_only, pop && !push, count == $past(count) - 1'b1, "pop lost")
  `PGSF_ASSERT(a_ptr_sync, (count == '0 || count == Q_CNT_W'(Q_DEPTH)) == (wr_ptr == rd_ptr),
               "pointers disagree with count")

endmodule

/* hw/rtl/pgsf_back.sv */
// Match engine: glob NFA and shift-and substring search, counters, result register.
// Depends on pgsf_pkg.
module pgsf_back
  import pgsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 cfg_we,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  q_entry_t             q_data,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tlast
);

  logic [CFG_LEN_W-1:0]   len_clamp;
  logic [LEN_W-1:0]       eff_len;
  logic [MAX_PATTERN-1:0] in_use, is_star, is_q, eq, step_mask, last_mask;
  logic [MAX_PATTERN:0]   len_mask;
  logic                   wild;

  logic [MAX_PATTERN:0]   init_closed, cur, ns, glob_new, glob_final;
  logic [MAX_PATTERN:0]   win_shift;
  logic [MAX_PATTERN-1:0] win_cur, win_new;
  logic                   found_new, found_final, matched;

  // per-path state; fresh marks the reset state so payload needs no clear
  logic                   fresh;
  logic [MAX_PATTERN:0]   glob;
  logic [MAX_PATTERN-1:0] win;
  logic                   found;

  logic [COUNT_BITS-1:0]  path_cnt, match_cnt, match_inc;
  logic                   pop;

  always_comb begin
    len_clamp = (cfg.length > CFG_LEN_W'(MAX_PATTERN)) ? CFG_LEN_W'(MAX_PATTERN) : cfg.length;
    eff_len   = len_clamp[LEN_W-1:0];
    for (int i = 0; i < MAX_PATTERN; i++) begin
      in_use[i]    = (i < int'(eff_len));
      is_star[i]   = in_use[i] && (cfg.pattern[8*i +: 8] == STAR_CHAR);
      is_q[i]      = in_use[i] && (cfg.pattern[8*i +: 8] == QMARK_CHAR);
      eq[i]        = in_use[i] && (fold_char(cfg.pattern[8*i +: 8]) == q_data.ch_fold);
      last_mask[i] = (i + 1 == int'(eff_len));
    end
    for (int i = 0; i <= MAX_PATTERN; i++) begin
      len_mask[i] = (i == int'(eff_len));
    end
    wild      = |(is_star | is_q);
    step_mask = (is_q | eq) & ~is_star;

    init_closed = star_close({{MAX_PATTERN{1'b0}}, 1'b1}, is_star);
    cur         = fresh ? init_closed : glob;
    ns          = {1'b0, cur[MAX_PATTERN-1:0] & is_star}
                | {cur[MAX_PATTERN-1:0] & step_mask, 1'b0};
    glob_new    = star_close(ns, is_star);

    win_cur   = fresh ? '0 : win;
    win_shift = {win_cur, 1'b1};
    win_new   = win_shift[MAX_PATTERN-1:0] & eq;
    found_new = (!fresh && found) || (|(win_new & last_mask));

    // a restart byte leaves the path in its reset state
    glob_final  = q_data.restart ? init_closed : glob_new;
    found_final = q_data.restart ? 1'b0 : found_new;

    if (eff_len == '0)  matched = 1'b1;
    else if (wild)      matched = |(glob_final & len_mask);
    else                matched = found_final;

    match_inc = (matched && match_cnt != '1) ? match_cnt + 1'b1 : match_cnt;
  end

  // non-final bytes never wait on the output side
  assign q_ready = !q_data.last || !m_tvalid || m_tready;
  assign pop     = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (pop && !q_data.restart && !q_data.last) begin
      glob  <= glob_new;
      win   <= win_new;
      found <= found_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh     <= 1'b1;
      path_cnt  <= '0;
      match_cnt <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        fresh <= 1'b1;
      end else if (pop) begin
        fresh <= q_data.restart || q_data.last;
      end
      if (pop && q_data.last) begin
        m_tvalid  <= 1'b1;
        path_cnt  <= q_data.fin ? '0 : ((path_cnt != '1) ? path_cnt + 1'b1 : path_cnt);
        match_cnt <= q_data.fin ? '0 : match_inc;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_data.last) begin
      m_tdata <= {{(M_TDATA_W - 2*OUT_CNT_W - 1){1'b0}},
                  OUT_CNT_W'(match_inc), OUT_CNT_W'(path_cnt), matched};
      m_tlast <= q_data.fin;
    end
  end

endmodule

/* hw/rtl/path_glob_substring_filter_core.sv */
// Top level of the path glob / substring filter: configuration registers and wiring.
// Depends on pgsf_pkg, pgsf_front, pgsf_queue and pgsf_back.
//
// Path bytes stream in one per cycle and each path yields one result on its last
// byte. A pattern holding '*' or '?' is an anchored, case-insensitive glob; any
// other pattern is a case-insensitive substring search; an empty pattern matches
// all. The match engine updates every pattern position in parallel, so the block
// sustains one byte per clock unless a last byte waits on a held result. Bytes pass
// the four-entry queue and the result register. Results hold in the output register
// while new bytes keep flowing into the queue. Write configuration only when idle.
module path_glob_substring_filter_core
  import pgsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  // path byte stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] character
  input  logic                 s_tlast,   // last_char
  input  logic [0:0]           s_tuser,   // [0] final_path
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [0] matched, [16:1] path_index,
                                          // [32:17] match_total, [39:33] zero
  output logic                 m_tlast    // list_done
);

  logic [PAT_REGS-1:0][63:0] pattern;
  logic [CFG_LEN_W-1:0]      length;
  logic                      scope_name;
  cfg_t                      cfg;

  q_entry_t                  f_entry;
  q_entry_t                  q_data;
  logic                      q_valid;
  logic                      q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern    <= '0;
      length     <= '0;
      scope_name <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        CFG_PAT0, CFG_PAT1, CFG_PAT2, CFG_PAT3: pattern[cfg_index[1:0]] <= cfg_data;
        CFG_LENGTH: length     <= cfg_data[CFG_LEN_W-1:0];
        CFG_SCOPE:  scope_name <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.pattern    = pattern;
  assign cfg.length     = length;
  assign cfg.scope_name = scope_name;

  pgsf_front u_front (
    .character  (s_tdata),
    .last_char  (s_tlast),
    .final_path (s_tuser[0]),
    .scope_name (scope_name),
    .entry      (f_entry)
  );

  pgsf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (f_entry),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  pgsf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cfg_we   (cfg_we),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

/* verif/pgsf_match_checker.sv */
`timescale 1ns / 100ps
// Result checker for path_glob_substring_filter_core: follows register writes and
// path byte transfers, predicts each path verdict and compares it with the result stream.
// Depends on pgsf_pkg for widths, register indexes and character codes.
module pgsf_match_checker
  import pgsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tlast,
  input  logic [0:0]           s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 m_tlast,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct packed {
    logic                 matched;
    logic [OUT_CNT_W-1:0] path_index;
    logic [OUT_CNT_W-1:0] match_total;
    logic                 list_done;
  } verdict_t;

  localparam logic [COUNT_BITS-1:0] CNT_TOP = '1;

  // shadow configuration
  logic [PAT_BITS-1:0]    pat_bytes;
  logic [CFG_LEN_W-1:0]   pat_len_reg;
  logic                   name_scope;
  // per-path match state
  logic [MAX_PATTERN:0]   live_pos;
  logic [MAX_PATTERN-1:0] shift_win;
  logic                   substr_hit;
  // list counters
  logic [COUNT_BITS-1:0]  path_seq;
  logic [COUNT_BITS-1:0]  match_seq;

  verdict_t verdicts_due[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c inside {[8'h41:8'h5A]}) return c | 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] pat_byte(input int i);
    return pat_bytes[i*8 +: 8];
  endfunction

  function automatic int used_len();
    return (pat_len_reg > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len_reg);
  endfunction

  // a live '*' position also makes the position after it live
  function automatic logic [MAX_PATTERN:0] close_stars(input logic [MAX_PATTERN:0] s,
                                                       input int len);
    for (int i = 0; i < len; i++)
      if (s[i] && pat_byte(i) == STAR_CHAR) s[i+1] = 1'b1;
    return s;
  endfunction

  function automatic logic [MAX_PATTERN:0] glob_next(input logic [MAX_PATTERN:0] s,
                                                     input logic [7:0] c, input int len);
    logic [MAX_PATTERN:0] ns;
    logic [7:0]           p;
    ns = '0;
    s  = close_stars(s, len);
    for (int i = 0; i < len; i++) begin
      if (s[i]) begin
        p = pat_byte(i);
        if (p == STAR_CHAR) ns[i] = 1'b1;
        else if (p == QMARK_CHAR || to_lower(p) == to_lower(c)) ns[i+1] = 1'b1;
      end
    end
    return close_stars(ns, len);
  endfunction

  function automatic void clear_path_state();
    live_pos   = 1;
    shift_win  = '0;
    substr_hit = 1'b0;
  endfunction

  function automatic void take_char(input logic [7:0] c, input logic last, input logic fin);
    int                     len;
    logic                   wild;
    logic                   ok;
    logic [MAX_PATTERN-1:0] hits;
    logic [MAX_PATTERN:0]   closed;
    verdict_t               v;
    len  = used_len();
    wild = 1'b0;
    hits = '0;
    for (int i = 0; i < len; i++) begin
      if (pat_byte(i) == STAR_CHAR || pat_byte(i) == QMARK_CHAR) wild = 1'b1;
      if (to_lower(pat_byte(i)) == to_lower(c)) hits[i] = 1'b1;
    end
    if (name_scope && c == BACKSLASH_CHAR) begin
      clear_path_state();
    end else begin
      live_pos  = glob_next(live_pos, c, len);
      shift_win = {shift_win[MAX_PATTERN-2:0], 1'b1} & hits;
      if (len > 0 && shift_win[len-1]) substr_hit = 1'b1;
    end
    if (last) begin
      closed = close_stars(live_pos, len);
      if (len == 0) ok = 1'b1;
      else if (wild) ok = closed[len];
      else ok = substr_hit;
      if (ok && match_seq != CNT_TOP) match_seq++;
      v.matched     = ok;
      v.path_index  = path_seq[OUT_CNT_W-1:0];
      v.match_total = match_seq[OUT_CNT_W-1:0];
      v.list_done   = fin;
      verdicts_due.push_back(v);
      if (path_seq != CNT_TOP) path_seq++;
      clear_path_state();
      if (fin) begin
        path_seq  = '0;
        match_seq = '0;
      end
    end
  endfunction

  task automatic report(input string what, input logic [M_TDATA_W-1:0] want,
                        input logic [M_TDATA_W-1:0] got);
    $display("%0t: result mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    mismatches++;
  endtask

  task automatic check_result();
    verdict_t want;
    if (verdicts_due.size() == 0) begin
      report("transfer with nothing expected", '0, m_tdata);
      return;
    end
    want = verdicts_due.pop_front();
    if (m_tdata[0] !== want.matched)
      report("matched", M_TDATA_W'(want.matched), M_TDATA_W'(m_tdata[0]));
    if (m_tdata[16:1] !== want.path_index)
      report("path_index", M_TDATA_W'(want.path_index), M_TDATA_W'(m_tdata[16:1]));
    if (m_tdata[32:17] !== want.match_total)
      report("match_total", M_TDATA_W'(want.match_total), M_TDATA_W'(m_tdata[32:17]));
    if (m_tlast !== want.list_done)
      report("list_done", M_TDATA_W'(want.list_done), M_TDATA_W'(m_tlast));
    if (m_tdata[M_TDATA_W-1:33] !== '0)
      report("tdata padding", '0, M_TDATA_W'(m_tdata[M_TDATA_W-1:33]));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pat_bytes   = '0;
      pat_len_reg = '0;
      name_scope  = 1'b1;
      path_seq    = '0;
      match_seq   = '0;
      clear_path_state();
      verdicts_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PAT0, CFG_PAT1, CFG_PAT2, CFG_PAT3: pat_bytes[cfg_index[1:0]*64 +: 64] = cfg_data;
          CFG_LENGTH: pat_len_reg = cfg_data[CFG_LEN_W-1:0];
          CFG_SCOPE:  name_scope  = cfg_data[0];
          default: ;
        endcase
        // any write, even to a spare index, restarts the path
        clear_path_state();
      end
      if (s_tvalid && s_tready) take_char(s_tdata[7:0], s_tlast, s_tuser[0]);
      if (m_tvalid && m_tready) check_result();
    end
    outstanding <= verdicts_due.size();
  end

endmodule

/* verif/path_glob_substring_filter_core_tb.sv */
`timescale 1ns / 100ps
// Testbench top for path_glob_substring_filter_core: drives registers, path bytes and
// result backpressure, and gives the verdict. Depends on pgsf_pkg and pgsf_match_checker.
module path_glob_substring_filter_core_tb;
  import pgsf_pkg::*;

  localparam int RANDOM_ITEMS = 750;
  localparam int STALL_LIMIT  = 5000;
  localparam int LONG_HOLD    = 80;
  localparam logic [2:0] CFG_SPARE0 = 3'd6;
  localparam logic [2:0] CFG_SPARE1 = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [2:0]           cfg_index = '0;
  logic [63:0]          cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tlast = 1'b0;
  logic [0:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;

  int   mismatches;
  int   outstanding;
  bit   calm = 1'b0;
  bit   hold_req = 1'b0;
  int   items_sent = 0;
  logic [7:0] pat [MAX_PATTERN];
  int   pat_used = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  path_glob_substring_filter_core dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

  pgsf_match_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast,
    .mismatches, .outstanding
  );

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if ((c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) && $urandom_range(0, 1)) return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] pattern_char(input bit wild_ok);
    case ($urandom_range(0, 11))
      0: return wild_ok ? STAR_CHAR : 8'h61;
      1: return wild_ok ? QMARK_CHAR : 8'h62;
      2: return 8'($urandom_range(0, 255));
      3: return BACKSLASH_CHAR;
      4: return 8'h00;
      default: return flip_case(8'h61 + 8'($urandom_range(0, 2)));
    endcase
  endfunction

  function automatic logic [7:0] path_char();
    case ($urandom_range(0, 9))
      0, 1: return 8'($urandom_range(0, 255));
      2: return BACKSLASH_CHAR;
      3: return 8'h00;
      4: return 8'hFF;
      5: return pat[$urandom_range(0, MAX_PATTERN - 1)];
      default: return flip_case(8'h61 + 8'($urandom_range(0, 2)));
    endcase
  endfunction

  // one register write; the task waits with cfg_we low before it returns
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_pattern(input int len_reg);
    logic [63:0] word;
    for (int r = 0; r < PAT_REGS; r++) begin
      for (int b = 0; b < 8; b++) word[b*8 +: 8] = pat[r*8 + b];
      write_reg(CFG_PAT0 + 3'(r), word);
    end
    word = {$urandom, $urandom};
    word[CFG_LEN_W-1:0] = CFG_LEN_W'(len_reg);
    write_reg(CFG_LENGTH, word);
    pat_used = (len_reg > MAX_PATTERN) ? MAX_PATTERN : len_reg;
  endtask

  task automatic write_scope(input bit name_only);
    logic [63:0] word;
    word = {$urandom, $urandom};
    word[0] = name_only;
    write_reg(CFG_SCOPE, word);
  endtask

  task automatic send_char(input logic [7:0] c, input bit last, input bit fin);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    s_tuser  <= fin;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_text(input string txt, input bit fin);
    for (int i = 0; i < txt.len(); i++) send_char(txt[i], i == txt.len() - 1, fin);
  endtask

  // mostly paths built around the pattern so that matches are common
  task automatic send_path(input bit fin);
    logic [7:0] body [$];
    bit         wild;
    wild = 1'b0;
    for (int i = 0; i < pat_used; i++)
      if (pat[i] == STAR_CHAR || pat[i] == QMARK_CHAR) wild = 1'b1;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 10)) body.push_back(path_char());
    end else begin
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(0, 3)) body.push_back(path_char());
        body.push_back(BACKSLASH_CHAR);
      end
      if (!wild) repeat ($urandom_range(0, 2)) body.push_back(path_char());
      for (int i = 0; i < pat_used; i++) begin
        if (wild && pat[i] == STAR_CHAR)
          repeat ($urandom_range(0, 2)) body.push_back(path_char());
        else if (wild && pat[i] == QMARK_CHAR) body.push_back(path_char());
        else body.push_back(flip_case(pat[i]));
      end
      if (!wild) repeat ($urandom_range(0, 2)) body.push_back(path_char());
      if ($urandom_range(0, 3) == 0 && body.size() > 0)
        body[$urandom_range(0, body.size() - 1)] = path_char();
    end
    if (body.size() == 0) body.push_back(path_char());
    for (int i = 0; i < body.size(); i++)
      send_char(body[i], i == body.size() - 1,
                (i == body.size() - 1) ? fin : bit'($urandom_range(0, 1)));
  endtask

  // stop offering and wait for every expected result, plus a margin
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_config(input int phase);
    int len;
    bit wild_ok;
    wild_ok = $urandom_range(0, 1);
    len = $urandom_range(0, 6);
    case (phase)
      0: begin wild_ok = 1'b0; len = $urandom_range(1, 4); end
      1: begin wild_ok = 1'b1; len = $urandom_range(2, 5); end
      6: len = MAX_PATTERN;
      default: ;
    endcase
    for (int i = 0; i < MAX_PATTERN; i++) pat[i] = pattern_char(wild_ok);
    if (phase == 3) begin
      foreach (pat[i]) pat[i] = 8'hFF;
      len = 63;
    end else if (phase == 5) begin
      foreach (pat[i]) pat[i] = 8'h00;
      len = MAX_PATTERN;
    end else if (phase == 8) begin
      len = $urandom_range(MAX_PATTERN + 1, 62);
    end
    write_pattern(len);
    write_scope($urandom_range(0, 1));
  endtask

  // result side: random stall bursts, one long hold on request
  initial begin
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ends the run if no transfer happens for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("path_glob_substring_filter_core_tb: errors");
    $finish;
  end

  initial begin
    int  phase;
    int  base;
    int  quota;
    bit  paused;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty pattern after reset, name scope on
    send_text("\\", 1'b0);
    settle();
    write_reg(CFG_SPARE0, {$urandom, $urandom});
    write_reg(CFG_SPARE1, '1);

    // substring with case folding, zero and all-ones bytes
    foreach (pat[i]) pat[i] = 8'h00;
    pat[0] = 8'h61;
    pat[1] = 8'h42;
    write_pattern(2);
    send_text("xAb", 1'b0);
    send_text("ab\\", 1'b0);
    send_char(8'h00, 1'b0, 1'b1);
    send_char(8'hFF, 1'b1, 1'b0);
    settle();
    write_scope(1'b0);
    send_text("ab\\c", 1'b0);

    // anchored glob, backslash as a plain byte, then name scope again
    settle();
    pat[0] = STAR_CHAR;
    pat[1] = 8'h61;
    pat[2] = QMARK_CHAR;
    write_pattern(3);
    send_text("x\\aZ", 1'b0);
    settle();
    write_scope(1'b1);
    send_text("Ab\\", 1'b0);
    send_text("za", 1'b0);
    send_text("aa", 1'b1);

    // length register beyond the pattern limit
    settle();
    foreach (pat[i]) pat[i] = STAR_CHAR;
    write_pattern(63);
    send_text("q", 1'b1);

    // match-all pattern back to back
    settle();
    write_pattern(0);
    send_text("a.b", 1'b0);
    send_char(8'h2E, 1'b1, 1'b1);

    // random phases
    phase  = 0;
    paused = 1'b0;
    base   = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      settle();
      random_config(phase);
      if (items_sent - base > RANDOM_ITEMS * 3 / 4) calm = 1'b1;
      if (phase == 2) hold_req = 1'b1;
      quota = items_sent + $urandom_range(40, 90);
      while (items_sent < quota) begin
        if (phase == 4 && !paused && items_sent > quota - 40) begin
          settle();
          paused = 1'b1;
        end
        send_path($urandom_range(0, 7) == 0);
      end
      phase++;
    end

    settle();
    if (mismatches == 0 && outstanding == 0)
      $display("path_glob_substring_filter_core_tb: clean");
    else
      $display("path_glob_substring_filter_core_tb: errors");
    $finish;
  end

endmodule
